### sv/cpra_pkg.sv
// cpra_pkg: shared widths, request kind codes and parameter defaults for the
// contiguous page run allocator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cpra_pkg;

	localparam int NUM_PAGES_DEF = 4096;
	localparam int WORD_BITS_DEF = 32;

	localparam int KIND_W     = 2;
	localparam int PAGE_IDX_W = 12;
	localparam int COUNT_W    = 13;
	localparam int MASK_W     = 12;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_FREE  = 2'd0;
	localparam kind_t KIND_USED  = 2'd1;
	localparam kind_t KIND_ALLOC = 2'd2;

endpackage

`default_nettype wire

### sv/cpra_word_scan.sv
// cpra_word_scan: evaluates one bitmap word of an allocation scan, all lanes at once.
// Depends on cpra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cpra_word_scan #(
	parameter int NUM_PAGES = cpra_pkg::NUM_PAGES_DEF,
	parameter int WORD_BITS = cpra_pkg::WORD_BITS_DEF
) (
	input  logic [WORD_BITS-1:0]                 map_word,
	input  logic [WORD_BITS-1:0]                 lt_count,
	input  logic [$clog2(NUM_PAGES+1)-1:0]       run_in,
	input  logic [$clog2(NUM_PAGES):0]           base_page,
	input  logic [cpra_pkg::COUNT_W-1:0]         page_count,
	input  logic [cpra_pkg::MASK_W-1:0]          boundary_mask,
	output logic                                 hit,
	output logic [$clog2(WORD_BITS)-1:0]         hit_lane,
	output logic [$clog2(NUM_PAGES):0]           start_page,
	output logic [$clog2(NUM_PAGES+1)-1:0]       run_out
);
	import cpra_pkg::*;

	localparam int PageW = $clog2(NUM_PAGES);
	localparam int AW    = PageW + 1;
	localparam int RunW  = $clog2(NUM_PAGES + 1);
	localparam int LaneW = $clog2(WORD_BITS);
	localparam int FitW  = ((AW > COUNT_W) ? AW : COUNT_W) + 1;

	logic [AW-1:0]        s_page [WORD_BITS];
	logic [WORD_BITS-1:0] fit;
	logic [WORD_BITS-1:0] carry;
	logic [WORD_BITS-1:0] window;
	logic [WORD_BITS-1:0] hit_vec;

	// Lane b ends a candidate run at page base+b; its run would start at
	// base+b+1-count. Window: the last count pages inside this word are free.
	// Carry: the pages before this word complete the run when it reaches back.
	always_comb begin
		for (int b = 0; b < WORD_BITS; b++) begin
			s_page[b] = base_page + AW'(b) + AW'(1) - AW'(page_count);
			fit[b] = (boundary_mask == '0) ||
				((FitW'(s_page[b] & AW'(boundary_mask)) + FitW'(page_count)) <=
				(FitW'(boundary_mask) + FitW'(1)));
			carry[b] = (FitW'(run_in) + FitW'(b) + FitW'(1)) >= FitW'(page_count);
			window[b] = 1'b1;
			for (int j = 0; j <= b; j++) begin
				window[b] = window[b] & (map_word[j] | ~lt_count[b-j]);
			end
		end
		hit_vec = fit & carry & window;
	end

	// lowest ending lane wins
	always_comb begin
		hit      = 1'b0;
		hit_lane = '0;
		for (int b = WORD_BITS - 1; b >= 0; b--) begin
			if (hit_vec[b]) begin
				hit      = 1'b1;
				hit_lane = LaneW'(b);
			end
		end
	end

	assign start_page = s_page[hit_lane];

	// free run that reaches the top of this word, for the next word
	always_comb begin
		run_out = run_in + RunW'(WORD_BITS);
		for (int b = 0; b < WORD_BITS; b++) begin
			if (!map_word[b]) begin
				run_out = RunW'(WORD_BITS - 1 - b);
			end
		end
	end

endmodule

`default_nettype wire

### sv/contiguous_page_run_allocator_unit.sv
// contiguous_page_run_allocator_unit: bitmap in one sync RAM; uses cpra_pkg, cpra_word_scan.
// Mark item: RAM read, then write back. Allocate: a scan of up to MapWords words
// (one bitmap word per cycle through the RAM read port), on a hit a write-back pass over the
// words spanned by the run, then loading the result register, which waits while it stalls.
// Reset: asynchronous, active low; afterwards a sweep writes MapWords zero words while
// req_stall is held high. One item is worked on at a time.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_page_run_allocator_unit #(
	parameter int NUM_PAGES = cpra_pkg::NUM_PAGES_DEF,
	parameter int WORD_BITS = cpra_pkg::WORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  cpra_pkg::kind_t                 kind,
	input  logic [cpra_pkg::PAGE_IDX_W-1:0] page_index,
	input  logic [cpra_pkg::COUNT_W-1:0]    page_count,
	input  logic [cpra_pkg::MASK_W-1:0]     boundary_mask,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output logic                            found,
	output logic [cpra_pkg::PAGE_IDX_W-1:0] grant_page
);
	import cpra_pkg::*;

	localparam int PageW    = $clog2(NUM_PAGES);
	localparam int AW       = PageW + 1;          // page arithmetic, room for one carry
	localparam int RunW     = $clog2(NUM_PAGES + 1);
	localparam int LaneW    = $clog2(WORD_BITS);
	localparam int MapWords = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WAddrW   = (MapWords > 1) ? $clog2(MapWords) : 1;
	localparam int LastWord = MapWords - 1;

	// page_index / WORD_BITS by reciprocal multiply; exact for all 12-bit indexes
	localparam int RecipS = PAGE_IDX_W + LaneW;
	localparam int RecipM = ((1 << RecipS) + WORD_BITS - 1) / WORD_BITS;
	localparam int RecipW = PAGE_IDX_W + 1;
	localparam int ProdW  = PAGE_IDX_W + RecipW;

	// sequencer states
	localparam logic [2:0] ST_CLR  = 3'd0;   // post-reset zero sweep
	localparam logic [2:0] ST_IDLE = 3'd1;
	localparam logic [2:0] ST_MARK = 3'd2;   // write back a marked word
	localparam logic [2:0] ST_SCAN = 3'd3;   // one word per cycle looking for a run
	localparam logic [2:0] ST_FILL = 3'd4;   // clear the run, top word down
	localparam logic [2:0] ST_RESP = 3'd5;   // hand result to the output register

	logic [2:0] state_q;

	//------------------------------------------------------------------
	// Bitmap RAM: set bit = page free. One read and one write port.
	//------------------------------------------------------------------
	logic [WORD_BITS-1:0] map_mem [MapWords];
	logic [WORD_BITS-1:0] rd_data_q;
	logic                 rd_en;
	logic [WAddrW-1:0]    rd_addr;
	logic                 wr_en;
	logic [WAddrW-1:0]    wr_addr;
	logic [WORD_BITS-1:0] wr_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			map_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= map_mem[rd_addr];
		end
	end

	//------------------------------------------------------------------
	// Request decode
	//------------------------------------------------------------------
	logic [ProdW-1:0]      mark_prod;
	logic [PAGE_IDX_W-1:0] mark_q_idx;
	logic [LaneW-1:0]      mark_lane;
	logic                  mark_ok;
	logic                  count_ok;
	logic [WORD_BITS-1:0]  lt_next;

	assign mark_prod  = ProdW'(page_index) * ProdW'(RecipM);
	assign mark_q_idx = PAGE_IDX_W'(mark_prod >> RecipS);
	assign mark_lane  = LaneW'(page_index - PAGE_IDX_W'(mark_q_idx * WORD_BITS));
	assign mark_ok    = 32'(page_index) < 32'(NUM_PAGES);
	assign count_ok   = (page_count != '0) && (32'(page_count) <= 32'(NUM_PAGES));

	// window masks for the scan: bit d says "d < page_count"
	always_comb begin
		for (int d = 0; d < WORD_BITS; d++) begin
			lt_next[d] = 32'(d) < 32'(page_count);
		end
	end

	logic acc;
	logic acc_mark;
	logic acc_alloc;

	assign req_stall = (state_q != ST_IDLE);
	assign acc       = (state_q == ST_IDLE) && req_valid;
	assign acc_mark  = acc && ((kind == KIND_FREE) || (kind == KIND_USED)) && mark_ok;
	assign acc_alloc = acc && (kind == KIND_ALLOC);
	// kind 3 and out-of-range marks are taken and dropped

	//------------------------------------------------------------------
	// Item registers
	//------------------------------------------------------------------
	logic [WAddrW-1:0]     clr_q;
	logic [WAddrW-1:0]     mark_word_q;
	logic [LaneW-1:0]      mark_lane_q;
	logic                  mark_free_q;
	logic [WAddrW-1:0]     pw_q;       // word whose data is on rd_data_q during scan
	logic [AW-1:0]         base_q;     // first page of word pw_q
	logic [RunW-1:0]       run_q;      // free pages running into word pw_q
	logic [WORD_BITS-1:0]  lt_q;
	logic [COUNT_W-1:0]    count_q;
	logic [MASK_W-1:0]     mask_q;
	logic [AW-1:0]         start_q;
	logic [AW-1:0]         end_q;
	logic [WAddrW-1:0]     fa_q;       // fill: next word to read
	logic [AW-1:0]         fab_q;
	logic [WAddrW-1:0]     fw_q;       // fill: word whose data is on rd_data_q
	logic [AW-1:0]         fwb_q;
	logic                  more_q;
	logic                  fv_q;
	logic                  res_found_q;
	logic [PAGE_IDX_W-1:0] res_first_q;
	logic                  rsp_valid_q;
	logic                  rsp_found_q;
	logic [PAGE_IDX_W-1:0] rsp_first_q;

	//------------------------------------------------------------------
	// Word scan
	//------------------------------------------------------------------
	logic             sc_hit;
	logic [LaneW-1:0] sc_lane;
	logic [AW-1:0]    sc_start;
	logic [RunW-1:0]  sc_run;

	cpra_word_scan #(
		.NUM_PAGES (NUM_PAGES),
		.WORD_BITS (WORD_BITS)
	) u_scan (
		.map_word      (rd_data_q),
		.lt_count      (lt_q),
		.run_in        (run_q),
		.base_page     (base_q),
		.page_count    (count_q),
		.boundary_mask (mask_q),
		.hit           (sc_hit),
		.hit_lane      (sc_lane),
		.start_page    (sc_start),
		.run_out       (sc_run)
	);

	logic scan_hit;
	logic scan_miss_end;
	logic fill_done;
	logic rsp_load;

	assign scan_hit      = (state_q == ST_SCAN) && sc_hit;
	assign scan_miss_end = (state_q == ST_SCAN) && !sc_hit && (pw_q == WAddrW'(LastWord));
	assign fill_done     = (state_q == ST_FILL) && fv_q && (fwb_q <= start_q);
	assign rsp_load      = (state_q == ST_RESP) && (!rsp_valid_q || !rsp_stall);

	// write-back data for a mark and for the run clear
	logic [WORD_BITS-1:0] mark_data;
	logic [WORD_BITS-1:0] fill_mask;
	logic [AW-1:0]        lane_page;

	always_comb begin
		lane_page = '0;
		for (int b = 0; b < WORD_BITS; b++) begin
			mark_data[b] = (LaneW'(b) == mark_lane_q) ? mark_free_q : rd_data_q[b];
			lane_page    = fwb_q + AW'(b);
			fill_mask[b] = (lane_page >= start_q) && (lane_page <= end_q);
		end
	end

	//------------------------------------------------------------------
	// RAM port control
	//------------------------------------------------------------------
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = pw_q;
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		unique case (state_q)
			ST_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			ST_IDLE: begin
				if (acc_mark) begin
					rd_en   = 1'b1;
					rd_addr = WAddrW'(mark_q_idx);
				end else if (acc_alloc && count_ok) begin
					rd_en   = 1'b1;
					rd_addr = '0;
				end
			end
			ST_MARK: begin
				wr_en   = 1'b1;
				wr_addr = mark_word_q;
				wr_data = mark_data;
			end
			ST_SCAN: begin
				// fetch the following word while this one is evaluated
				if (!sc_hit && (pw_q != WAddrW'(LastWord))) begin
					rd_en   = 1'b1;
					rd_addr = pw_q + WAddrW'(1);
				end
			end
			ST_FILL: begin
				// read word n-1 while word n is written: never the same entry
				if (more_q) begin
					rd_en   = 1'b1;
					rd_addr = fa_q;
				end
				if (fv_q) begin
					wr_en   = 1'b1;
					wr_addr = fw_q;
					wr_data = rd_data_q & ~fill_mask;
				end
			end
			default: begin
			end
		endcase
	end

	//------------------------------------------------------------------
	// Control state
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_q       <= '0;
			more_q      <= 1'b0;
			fv_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + WAddrW'(1);
					if (clr_q == WAddrW'(LastWord)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc_mark) begin
						state_q <= ST_MARK;
					end else if (acc_alloc) begin
						state_q <= count_ok ? ST_SCAN : ST_RESP;
					end
				end
				ST_MARK: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_hit) begin
						state_q <= ST_FILL;
						more_q  <= 1'b1;
						fv_q    <= 1'b0;
					end else if (scan_miss_end) begin
						state_q <= ST_RESP;
					end
				end
				ST_FILL: begin
					fv_q   <= more_q;
					more_q <= more_q && (fab_q > start_q);
					if (fill_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	//------------------------------------------------------------------
	// Payload registers
	//------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (acc_mark) begin
			mark_word_q <= WAddrW'(mark_q_idx);
			mark_lane_q <= mark_lane;
			mark_free_q <= (kind == KIND_FREE);
		end

		if (acc_alloc) begin
			count_q     <= page_count;
			mask_q      <= boundary_mask;
			lt_q        <= lt_next;
			pw_q        <= '0;
			base_q      <= '0;
			run_q       <= '0;
			res_found_q <= 1'b0;
			res_first_q <= '0;
		end

		if (state_q == ST_SCAN) begin
			if (sc_hit) begin
				start_q     <= sc_start;
				end_q       <= base_q + AW'(sc_lane);
				fa_q        <= pw_q;
				fab_q       <= base_q;
				res_found_q <= 1'b1;
				res_first_q <= PAGE_IDX_W'(sc_start);
			end else if (pw_q != WAddrW'(LastWord)) begin
				pw_q   <= pw_q + WAddrW'(1);
				base_q <= base_q + AW'(WORD_BITS);
				run_q  <= sc_run;
			end
		end

		if (state_q == ST_FILL) begin
			if (more_q) begin
				fa_q  <= fa_q - WAddrW'(1);
				fab_q <= fab_q - AW'(WORD_BITS);
			end
			fw_q  <= fa_q;
			fwb_q <= fab_q;
		end

		if (rsp_load) begin
			rsp_found_q <= res_found_q;
			rsp_first_q <= res_first_q;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign found      = rsp_found_q;
	assign grant_page = rsp_first_q;

	//------------------------------------------------------------------
	// Checks
	//------------------------------------------------------------------

	// every page the clear pass takes must have been free
	a_fill_run_free: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_FILL) && fv_q) |-> ((rd_data_q & fill_mask) == fill_mask))
		else $error("run clear hit a page that was not free");

	// the recorded run spans exactly the requested page count
	a_run_span: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> (end_q == start_q + AW'(count_q) - AW'(1)))
		else $error("run end does not match start and count");

	// the carried free run never reaches back past page zero
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (AW'(run_q) <= base_q))
		else $error("carried run longer than pages scanned");

endmodule

`default_nettype wire
